/* sv/frob_pkg.sv */
// Shared types and fixed constants for the Frobenius-form reduction block.
// No dependencies; imported by frob_ram's users, frob_alu and the top level.
`timescale 1ns / 1ps
`default_nettype none

package frob_pkg;

    // APB register map
    localparam int          CFG_AW         = 3;
    localparam int          CFG_DW         = 32;
    localparam logic        REG_MATRIX_SIZE = 1'b0;   // paddr[2] selects the register
    localparam logic [3:0]  SIZE_RESET     = 4'd8;

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_PIV_RD,
        ST_PIV_CHK,
        ST_ROW_RD,
        ST_ROW_DIV,
        ST_ROW_WAIT,
        ST_P1_RD,
        ST_P1_MUL,
        ST_P1_WAIT,
        ST_P2_PIV_RD,
        ST_P2_PIV,
        ST_P2_RD,
        ST_P2_MUL,
        ST_P2_WAIT,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_EMIT_WAIT
    } frob_state_t;

    typedef enum logic {
        ALU_MUL,
        ALU_DIV
    } alu_op_t;

    typedef enum logic [2:0] {
        A_IDLE,
        A_MUL,
        A_DIV,
        A_ROUND,
        A_SAT
    } alu_state_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_req_t;

endpackage

`default_nettype wire

/* sv/frob_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module frob_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

/* sv/frob_alu.sv */
// Shared fixed-point unit: rounded, saturated multiply (four 32x32 partial
// products) and rounded, saturated divide (restoring, one bit per cycle).
// Depends on frob_pkg.
`timescale 1ns / 1ps
`default_nettype none

module frob_alu
    import frob_pkg::*;
#(
    parameter int DATA_WIDTH    = 48,
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire alu_req_t                     req,
    input  wire logic signed [DATA_WIDTH-1:0] a,
    input  wire logic signed [DATA_WIDTH-1:0] b,
    output logic                              done,
    output logic signed [DATA_WIDTH-1:0]      result
);

    localparam int DW = DATA_WIDTH;
    localparam int NB = DATA_WIDTH + FRACTION_BITS;
    localparam logic [127:0] HALF  = 128'(1) << (FRACTION_BITS - 1);
    localparam logic [127:0] QMASK = {128{1'b1}} >> (128 - NB);
    localparam logic [127:0] LIM_P = (128'(1) << (DW - 1)) - 128'(1);
    localparam logic [127:0] LIM_N = 128'(1) << (DW - 1);
    localparam logic signed [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};

    alu_state_t      st_reg, st_next;
    alu_op_t         op_reg;
    logic [6:0]      cnt_reg;
    logic [127:0]    acc_reg;
    logic [DW-1:0]   rem_reg;
    logic [63:0]     ma_reg, mb_reg;
    logic            neg_reg;

    logic [DW-1:0]   mag_a, mag_b;
    logic [31:0]     ha, hb;
    logic [63:0]     pp;
    logic [127:0]    pp_sh;
    logic [DW:0]     rem_sh;
    logic            q_bit;
    logic            rnd_up;

    assign mag_a = a[DW-1] ? DW'(-a) : DW'(a);
    assign mag_b = b[DW-1] ? DW'(-b) : DW'(b);

    assign ha = cnt_reg[1] ? ma_reg[63:32] : ma_reg[31:0];
    assign hb = cnt_reg[0] ? mb_reg[63:32] : mb_reg[31:0];
    assign pp = 64'(ha) * 64'(hb);

    always_comb
    begin
        case (2'(32'(cnt_reg[0]) + 32'(cnt_reg[1])))
            2'd0:    pp_sh = {64'd0, pp};
            2'd1:    pp_sh = {32'd0, pp, 32'd0};
            default: pp_sh = {pp, 64'd0};
        endcase
    end

    assign rem_sh = {rem_reg, acc_reg[NB-1]};
    assign q_bit  = rem_sh >= {1'b0, mb_reg[DW-1:0]};
    assign rnd_up = {rem_reg, 1'b0} >= {1'b0, mb_reg[DW-1:0]};

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            A_IDLE:
            begin
                if (req.start)
                begin
                    st_next = (req.op == ALU_MUL) ? A_MUL : A_DIV;
                end
            end
            A_MUL:
            begin
                if (cnt_reg[1:0] == 2'd3)
                begin
                    st_next = A_ROUND;
                end
            end
            A_DIV:
            begin
                if (cnt_reg == 7'(NB - 1))
                begin
                    st_next = A_ROUND;
                end
            end
            A_ROUND: st_next = A_SAT;
            A_SAT:   st_next = A_IDLE;
            default: st_next = A_IDLE;
        endcase
    end

    always_comb
    begin
        done   = 1'b0;
        result = '0;
        case (st_reg)
            A_SAT:
            begin
                done = 1'b1;
                if (acc_reg > (neg_reg ? LIM_N : LIM_P))
                begin
                    result = neg_reg ? MINV : MAXV;
                end
                else
                begin
                    result = neg_reg ? -$signed(acc_reg[DW-1:0]) : $signed(acc_reg[DW-1:0]);
                end
            end
            default:
            begin
                done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= A_IDLE;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (st_reg)
            A_IDLE:
            begin
                ma_reg  <= 64'(mag_a);
                mb_reg  <= 64'(mag_b);
                neg_reg <= a[DW-1] ^ b[DW-1];
                op_reg  <= req.op;
                cnt_reg <= '0;
                rem_reg <= '0;
                acc_reg <= (req.op == ALU_MUL) ? 128'd0 : (128'(mag_a) << FRACTION_BITS);
            end
            A_MUL:
            begin
                acc_reg <= acc_reg + pp_sh;
                cnt_reg <= cnt_reg + 7'd1;
            end
            A_DIV:
            begin
                rem_reg <= q_bit ? DW'(rem_sh - {1'b0, mb_reg[DW-1:0]}) : rem_sh[DW-1:0];
                acc_reg <= {acc_reg[126:0], q_bit};
                cnt_reg <= cnt_reg + 7'd1;
            end
            A_ROUND:
            begin
                if (op_reg == ALU_MUL)
                begin
                    acc_reg <= (acc_reg + HALF) >> FRACTION_BITS;
                end
                else
                begin
                    acc_reg <= (acc_reg & QMASK) + 128'(rnd_up);
                end
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> st_reg == A_IDLE)
        else $error("unit started while busy");
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (req.start && req.op == ALU_DIV) |-> b != '0)
        else $error("divide by zero pivot");
    a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");
`endif

endmodule

`default_nettype wire

/* sv/frobenius_form_reduction.sv */
// Frobenius-form reduction: element load, Danilevsky step sequencer, result emit.
// Depends on frob_pkg, frob_ram, frob_alu.
//
// Usage: configure matrix_size (1..MAX_SIZE; 0 acts as 1, larger as MAX_SIZE)
// over APB at address 0 while idle; a write drops any partly loaded matrix.
// Stream n*n elements row-major on s_tdata. On the final element the block
// drops s_tready and reduces the matrix for k = n down to 2 on one shared
// multiply/divide unit, then streams the n*n results row-major on m_tdata,
// with m_tlast on the last one and m_tuser set on every result when a zero
// pivot stopped the reduction. s_tready returns after the final result.
// A stalled receiver holds the current result in the output register and
// the sequencer waits. Reset clears the load position and sets matrix_size
// to 8; the matrix and product stores need no clearing.
`timescale 1ns / 1ps
`default_nettype none

module frobenius_form_reduction
    import frob_pkg::*;
#(
    parameter int MAX_SIZE      = 8,
    parameter int FRACTION_BITS = 16,
    parameter int DATA_WIDTH    = 48
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    input  wire logic [((DATA_WIDTH+7)/8)*8-1:0]       s_tdata,   // element_value
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    output logic      [((DATA_WIDTH+7)/8)*8-1:0]       m_tdata,   // result_value
    output logic                                       m_tlast,   // last_element
    output logic                                       m_tuser,   // pivot_error
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [CFG_AW-1:0]                     paddr,
    input  wire logic [CFG_DW-1:0]                     pwdata,
    output logic      [CFG_DW-1:0]                     prdata,
    output logic                                       pready
);

    localparam int DW    = DATA_WIDTH;
    localparam int TDW   = ((DATA_WIDTH + 7) / 8) * 8;
    localparam int DEPTH = MAX_SIZE * MAX_SIZE;
    localparam int AW    = $clog2(DEPTH);
    localparam int IW    = $clog2(MAX_SIZE);
    localparam int NW    = $clog2(MAX_SIZE + 1);
    localparam logic signed [DW-1:0] ONE  = DW'(1) << FRACTION_BITS;
    localparam logic signed [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};

    function automatic logic signed [DW-1:0] sat_add(input logic signed [DW-1:0] x,
                                                      input logic signed [DW-1:0] y);
        logic [DW:0] s;
        s = {x[DW-1], x} + {y[DW-1], y};
        if (s[DW] != s[DW-1])
        begin
            return s[DW] ? MINV : MAXV;
        end
        return $signed(s[DW-1:0]);
    endfunction

    function automatic logic [AW-1:0] cell_addr(input logic [IW-1:0] r, input logic [IW-1:0] c);
        return AW'(32'(r) * MAX_SIZE) + AW'(c);
    endfunction

    frob_state_t state_reg, state_next;
    logic [3:0]  size_reg;
    logic [IW-1:0] lr_reg, lc_reg;
    logic [IW-1:0] k_reg, i_reg, j_reg, t_reg;
    logic signed [DW-1:0] pivot_reg, acc_reg, pip_reg, pij_reg;
    logic signed [DW-1:0] rowk_reg [MAX_SIZE];
    logic signed [DW-1:0] mrow_reg [MAX_SIZE];
    logic        err_reg;
    logic [DW-1:0] out_data_reg;
    logic        out_last_reg;

    logic [NW-1:0] n, n_last;
    logic [IW-1:0] pr;
    logic        i_last, j_last, t_last, lr_last, lc_last, k_first, i_is_pr, j_is_pr;
    logic        cfg_wr, s_xfer, m_xfer;

    logic [IW-1:0] rd_row, rd_col, wr_row, wr_col;
    logic        mat_we, prod_we, use_prod;
    logic signed [DW-1:0] mat_wdata;
    logic [DW-1:0] mat_rdata, prod_rdata;
    logic signed [DW-1:0] rd_data, neg_rd, mac_sum, p2_val;

    alu_req_t    alu_req;
    logic signed [DW-1:0] alu_a, alu_b, alu_res;
    logic        alu_done;

    always_comb
    begin
        if (size_reg == 4'd0)
        begin
            n = NW'(1);
        end
        else if (32'(size_reg) > MAX_SIZE)
        begin
            n = NW'(MAX_SIZE);
        end
        else
        begin
            n = NW'(size_reg);
        end
    end

    assign n_last  = n - NW'(1);
    assign pr      = k_reg - IW'(1);
    assign i_last  = NW'(i_reg) == n_last;
    assign j_last  = NW'(j_reg) == n_last;
    assign t_last  = NW'(t_reg) == n_last;
    assign lr_last = NW'(lr_reg) == n_last;
    assign lc_last = NW'(lc_reg) == n_last;
    assign k_first = k_reg == IW'(1);
    assign i_is_pr = i_reg == pr;
    assign j_is_pr = j_reg == pr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_MATRIX_SIZE);
    assign prdata = (paddr[2] == REG_MATRIX_SIZE) ? CFG_DW'(size_reg) : '0;
    assign s_xfer = s_tvalid && s_tready;
    assign m_xfer = m_tvalid && m_tready;

    assign rd_data = use_prod ? $signed(prod_rdata) : $signed(mat_rdata);
    assign neg_rd  = ($signed(mat_rdata) == MINV) ? MAXV : -$signed(mat_rdata);
    assign mac_sum = sat_add(acc_reg, alu_res);
    assign p2_val  = j_is_pr ? alu_res : sat_add(pij_reg, alu_res);

    assign m_tdata = TDW'(out_data_reg);
    assign m_tlast = out_last_reg;
    assign m_tuser = err_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (s_xfer && lc_last && lr_last)
                begin
                    state_next = (n == NW'(1)) ? ST_EMIT_RD : ST_PIV_RD;
                end
            end
            ST_PIV_RD:   state_next = ST_PIV_CHK;
            ST_PIV_CHK:  state_next = (mat_rdata == '0) ? ST_EMIT_RD : ST_ROW_RD;
            ST_ROW_RD:   state_next = ST_ROW_DIV;
            ST_ROW_DIV:  state_next = ST_ROW_WAIT;
            ST_ROW_WAIT:
            begin
                if (alu_done)
                begin
                    state_next = j_last ? ST_P1_RD : ST_ROW_RD;
                end
            end
            ST_P1_RD:    state_next = ST_P1_MUL;
            ST_P1_MUL:   state_next = ST_P1_WAIT;
            ST_P1_WAIT:
            begin
                if (alu_done)
                begin
                    state_next = (t_last && j_last) ? ST_P2_PIV_RD : ST_P1_RD;
                end
            end
            ST_P2_PIV_RD: state_next = ST_P2_PIV;
            ST_P2_PIV:    state_next = ST_P2_RD;
            ST_P2_RD:     state_next = ST_P2_MUL;
            ST_P2_MUL:    state_next = ST_P2_WAIT;
            ST_P2_WAIT:
            begin
                if (alu_done)
                begin
                    if (!j_last)
                    begin
                        state_next = ST_P2_RD;
                    end
                    else if (!i_last)
                    begin
                        state_next = ST_P2_PIV_RD;
                    end
                    else
                    begin
                        state_next = k_first ? ST_EMIT_RD : ST_PIV_RD;
                    end
                end
            end
            ST_EMIT_RD: state_next = ST_EMIT_LD;
            ST_EMIT_LD: state_next = ST_EMIT_WAIT;
            ST_EMIT_WAIT:
            begin
                if (m_tready)
                begin
                    state_next = out_last_reg ? ST_LOAD : ST_EMIT_RD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    // outputs: memory ports, unit requests, handshakes
    always_comb
    begin
        s_tready    = 1'b0;
        m_tvalid    = 1'b0;
        rd_row      = i_reg;
        rd_col      = j_reg;
        wr_row      = i_reg;
        wr_col      = j_reg;
        mat_we      = 1'b0;
        mat_wdata   = p2_val;
        prod_we     = 1'b0;
        use_prod    = 1'b0;
        alu_req     = '{start: 1'b0, op: ALU_MUL};
        alu_a       = acc_reg;
        alu_b       = pivot_reg;
        case (state_reg)
            ST_LOAD:
            begin
                s_tready  = 1'b1;
                wr_row    = lr_reg;
                wr_col    = lc_reg;
                mat_we    = s_xfer;
                mat_wdata = $signed(s_tdata[DW-1:0]);
            end
            ST_PIV_RD:
            begin
                rd_row = k_reg;
                rd_col = pr;
            end
            ST_ROW_RD:
            begin
                rd_row = k_reg;
            end
            ST_ROW_DIV:
            begin
                alu_req = '{start: 1'b1, op: ALU_DIV};
                alu_a   = j_is_pr ? ONE : neg_rd;
                alu_b   = pivot_reg;
            end
            ST_P1_RD:
            begin
                rd_row = t_reg;
            end
            ST_P1_MUL:
            begin
                alu_req = '{start: 1'b1, op: ALU_MUL};
                alu_a   = rowk_reg[t_reg];
                alu_b   = $signed(mat_rdata);
            end
            ST_P1_WAIT:
            begin
                wr_row  = pr;
                prod_we = alu_done && t_last;
            end
            ST_P2_PIV_RD:
            begin
                rd_col = pr;
            end
            ST_P2_PIV:
            begin
                use_prod = i_is_pr;
            end
            ST_P2_MUL:
            begin
                use_prod = i_is_pr;
                alu_req  = '{start: 1'b1, op: ALU_MUL};
                alu_a    = pip_reg;
                alu_b    = mrow_reg[j_reg];
            end
            ST_P2_WAIT:
            begin
                mat_we = alu_done;
            end
            ST_EMIT_WAIT:
            begin
                m_tvalid = 1'b1;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            size_reg  <= SIZE_RESET;
            lr_reg    <= '0;
            lc_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr)
            begin
                size_reg <= pwdata[3:0];
                lr_reg   <= '0;
                lc_reg   <= '0;
            end
            else if (s_xfer)
            begin
                if (lc_last)
                begin
                    lc_reg <= '0;
                    lr_reg <= lr_last ? '0 : lr_reg + IW'(1);
                end
                else
                begin
                    lc_reg <= lc_reg + IW'(1);
                end
            end
        end
    end

    // sequencer datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_LOAD:
            begin
                k_reg   <= IW'(n_last);
                i_reg   <= '0;
                j_reg   <= '0;
                err_reg <= 1'b0;
            end
            ST_PIV_CHK:
            begin
                pivot_reg <= $signed(mat_rdata);
                j_reg     <= '0;
                i_reg     <= '0;
                err_reg   <= mat_rdata == '0;
            end
            ST_ROW_DIV:
            begin
                rowk_reg[j_reg] <= $signed(mat_rdata);
            end
            ST_ROW_WAIT:
            begin
                if (alu_done)
                begin
                    mrow_reg[j_reg] <= alu_res;
                    j_reg   <= j_last ? '0 : j_reg + IW'(1);
                    t_reg   <= '0;
                    acc_reg <= '0;
                end
            end
            ST_P1_WAIT:
            begin
                if (alu_done)
                begin
                    if (t_last)
                    begin
                        acc_reg <= '0;
                        t_reg   <= '0;
                        j_reg   <= j_last ? '0 : j_reg + IW'(1);
                        i_reg   <= '0;
                    end
                    else
                    begin
                        acc_reg <= mac_sum;
                        t_reg   <= t_reg + IW'(1);
                    end
                end
            end
            ST_P2_PIV:
            begin
                pip_reg <= rd_data;
                j_reg   <= '0;
            end
            ST_P2_MUL:
            begin
                pij_reg <= rd_data;
            end
            ST_P2_WAIT:
            begin
                if (alu_done)
                begin
                    j_reg <= j_last ? '0 : j_reg + IW'(1);
                    if (j_last)
                    begin
                        i_reg <= i_last ? '0 : i_reg + IW'(1);
                        if (i_last)
                        begin
                            k_reg <= k_reg - IW'(1);
                        end
                    end
                end
            end
            ST_EMIT_LD:
            begin
                out_data_reg <= mat_rdata;
                out_last_reg <= i_last && j_last;
            end
            ST_EMIT_WAIT:
            begin
                if (m_tready)
                begin
                    j_reg <= j_last ? '0 : j_reg + IW'(1);
                    if (j_last)
                    begin
                        i_reg <= i_reg + IW'(1);
                    end
                end
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    frob_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_matrix_ram (
        .clk   (clk),
        .we    (mat_we),
        .waddr (cell_addr(wr_row, wr_col)),
        .wdata (mat_wdata),
        .raddr (cell_addr(rd_row, rd_col)),
        .rdata (mat_rdata)
    );

    frob_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_product_ram (
        .clk   (clk),
        .we    (prod_we),
        .waddr (cell_addr(wr_row, wr_col)),
        .wdata (mac_sum),
        .raddr (cell_addr(rd_row, rd_col)),
        .rdata (prod_rdata)
    );

    frob_alu #(.DATA_WIDTH(DW), .FRACTION_BITS(FRACTION_BITS)) u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (alu_req),
        .a      (alu_a),
        .b      (alu_b),
        .done   (alu_done),
        .result (alu_res)
    );

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input accepted while a result is pending");
    a_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        alu_done |-> (state_reg == ST_ROW_WAIT || state_reg == ST_P1_WAIT
                      || state_reg == ST_P2_WAIT))
        else $error("unit result arrived outside a wait state");
    a_prod_row: assert property (@(posedge clk) disable iff (!rst_n)
        prod_we |-> (wr_row == pr && state_reg == ST_P1_WAIT))
        else $error("product store written outside pivot row");
    a_last_end: assert property (@(posedge clk) disable iff (!rst_n)
        (m_xfer && m_tlast) |=> state_reg == ST_LOAD)
        else $error("did not return to loading after last result");
`endif

endmodule

`default_nettype wire

/* tb/tb_frobenius_form_reduction.sv */
// Testbench for frobenius_form_reduction: streams matrices of several orders,
// predicts the Danilevsky reduction in fixed point and checks every result.
// Depends on frob_pkg and the frobenius_form_reduction RTL.
`timescale 1ns / 1ps

module tb_frobenius_form_reduction
    import frob_pkg::*;
();

    localparam int     MAX_N    = 8;
    localparam int     FRAC     = 16;
    localparam int     DW       = 48;
    localparam longint MAXV     = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint MINV     = -MAXV - 1;
    localparam longint ONE      = 64'sd1 << FRAC;
    localparam int     IDLE_LIM = 100000;
    localparam logic [CFG_AW-1:0] ADDR_SIZE   = 3'd0;
    localparam logic [CFG_AW-1:0] ADDR_UNUSED = 3'd4;

    typedef struct {
        logic [DW-1:0] value;
        bit            last;
        bit            pivot_err;
    } frob_result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_tvalid;
    logic              s_tready;
    logic [DW-1:0]     s_tdata;      // element_value
    logic              m_tvalid;
    logic              m_tready;
    logic [DW-1:0]     m_tdata;      // result_value
    logic              m_tlast;      // last_element
    logic              m_tuser;      // pivot_error
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [CFG_AW-1:0] paddr;
    logic [CFG_DW-1:0] pwdata;
    logic [CFG_DW-1:0] prdata;
    logic              pready;

    frobenius_form_reduction i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #1 clk = ~clk;

    logic [DW-1:0] element_q[$];
    frob_result_t  frob_result_q[$];
    int            errors;
    int            results_seen;
    int            matrices_seen;
    int            pivot_err_seen;
    int            items_sent;

    // predictor state
    longint        mat[MAX_N][MAX_N];
    longint        prod[MAX_N][MAX_N];
    int            load_cnt;
    int            size_reg;

    function automatic int order_of(int sz);
        if (sz == 0) return 1;
        if (sz > MAX_N) return MAX_N;
        return sz;
    endfunction

    function automatic bit [127:0] mag(longint a);
        return (a < 0) ? 128'(-a) : 128'(a);
    endfunction

    function automatic longint from_mag(bit [127:0] q, bit neg);
        if (neg)
        begin
            if (q > 128'(MAXV) + 1) return MINV;
            return -longint'(q[63:0]);
        end
        if (q > 128'(MAXV)) return MAXV;
        return longint'(q[63:0]);
    endfunction

    function automatic longint q_add(longint a, longint b);
        longint s;
        s = a + b;
        if (s > MAXV) return MAXV;
        if (s < MINV) return MINV;
        return s;
    endfunction

    function automatic longint q_mul(longint a, longint b);
        bit [127:0] p;
        p = mag(a) * mag(b);
        p = (p + (128'd1 << (FRAC - 1))) >> FRAC;
        return from_mag(p, (a < 0) != (b < 0));
    endfunction

    function automatic longint q_div(longint a, longint b);
        bit [127:0] num;
        bit [127:0] den;
        bit [127:0] q;
        bit [127:0] r;
        num = mag(a) << FRAC;
        den = mag(b);
        q   = num / den;
        r   = num % den;
        if (r >= den - r) q = q + 1;
        return from_mag(q, (a < 0) != (b < 0));
    endfunction

    // Danilevsky steps for k = n-1 down to 1 (zero-based); 1 on a zero pivot
    function automatic bit danilevsky(int n);
        longint mrow[MAX_N];
        longint acc;
        longint m1;
        longint mm;
        longint p;
        int     pr;
        for (int k = n - 1; k >= 1; k--)
        begin
            pr = k - 1;
            p  = mat[k][pr];
            if (p == 0) return 1'b1;
            for (int j = 0; j < n; j++)
                mrow[j] = (j == pr) ? q_div(ONE, p) : q_div(q_mul(-ONE, mat[k][j]), p);
            for (int i = 0; i < n; i++)
                for (int j = 0; j < n; j++)
                begin
                    acc = 0;
                    for (int t = 0; t < n; t++)
                    begin
                        m1  = (i == pr) ? mat[k][t] : ((i == t) ? ONE : 0);
                        acc = q_add(acc, q_mul(m1, mat[t][j]));
                    end
                    prod[i][j] = acc;
                end
            for (int i = 0; i < n; i++)
                for (int j = 0; j < n; j++)
                begin
                    acc = 0;
                    for (int t = 0; t < n; t++)
                    begin
                        mm  = (t == pr) ? mrow[j] : ((t == j) ? ONE : 0);
                        acc = q_add(acc, q_mul(prod[i][t], mm));
                    end
                    mat[i][j] = acc;
                end
        end
        return 1'b0;
    endfunction

    task automatic load_element(logic [DW-1:0] d);
        int           n;
        bit           err;
        frob_result_t r;
        n = order_of(size_reg);
        if (load_cnt >= n * n) load_cnt = 0;
        mat[load_cnt / n][load_cnt % n] = longint'($signed(d));
        load_cnt++;
        if (load_cnt == n * n)
        begin
            load_cnt = 0;
            err = danilevsky(n);
            for (int idx = 0; idx < n * n; idx++)
            begin
                r.value     = mat[idx / n][idx % n][DW-1:0];
                r.last      = (idx == n * n - 1);
                r.pivot_err = err;
                frob_result_q.push_back(r);
            end
        end
    endtask

    always @(posedge clk)
        if (rst_n && s_tvalid && s_tready)
            load_element(s_tdata);

    // sender: bursts with random gaps
    int burst_left;
    int gap_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                void'(element_q.pop_front());
                items_sent++;
                if (burst_left > 0) burst_left--;
            end
            if (!(s_tvalid && !s_tready))
            begin
                if (burst_left == 0 && gap_left == 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
                end
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (element_q.size() > 0)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= element_q[0];
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: stall pattern, plus one long hold-off once results flow
    int  rdy_mode;
    int  hold_cnt;
    bit  hold_done;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            rdy_mode  = 0;
            hold_cnt  = 0;
            hold_done = 1'b0;
        end
        else if (hold_cnt > 0)
        begin
            hold_cnt--;
            m_tready <= 1'b0;
        end
        else if (!hold_done && results_seen >= 150)
        begin
            hold_done = 1'b1;
            hold_cnt  = 3000;
            m_tready  <= 1'b0;
        end
        else
        begin
            if ($urandom_range(0, 63) == 0) rdy_mode = $urandom_range(0, 2);
            case (rdy_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= $urandom_range(0, 1);
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    task automatic report(string what, logic [DW-1:0] got, logic [DW-1:0] want);
        $display("MISMATCH %s at result %0d: got %h want %h", what, results_seen, got, want);
        errors++;
    endtask

    always @(posedge clk)
    begin
        frob_result_t w;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (frob_result_q.size() == 0)
                report("unexpected result", m_tdata, '0);
            else
            begin
                w = frob_result_q.pop_front();
                if (m_tdata !== w.value) report("result_value", m_tdata, w.value);
                if (m_tlast !== w.last) report("last_element", DW'(m_tlast), DW'(w.last));
                if (m_tuser !== w.pivot_err)
                    report("pivot_error", DW'(m_tuser), DW'(w.pivot_err));
                if (w.last) matrices_seen++;
                if (w.last && w.pivot_err) pivot_err_seen++;
            end
            results_seen++;
        end
    end

    // watchdog on cycles without any transfer
    int idle_cycles;
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIM)
        begin
            $display("timeout: no transfer for %0d cycles", IDLE_LIM);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic wait_idle();
        while (element_q.size() != 0 || s_tvalid || frob_result_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic cfg_write(logic [CFG_AW-1:0] addr, logic [CFG_DW-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr[2] == REG_MATRIX_SIZE)
        begin
            size_reg = data & 32'hF;
            load_cnt = 0;
        end
    endtask

    function automatic logic [DW-1:0] rand_element();
        longint      v;
        logic [63:0] w;
        case ($urandom_range(0, 11))
            0:
            begin
                w = {$urandom, $urandom};
                return w[DW-1:0];
            end
            1:       return '0;
            2:       v = (longint'($urandom_range(0, 8)) - 4) * ONE;
            3:       v = ($urandom_range(0, 1) == 1) ? MAXV : MINV;
            default: v = longint'($urandom_range(0, 32'(8 * ONE))) - 4 * ONE;
        endcase
        return v[DW-1:0];
    endfunction

    task automatic send_matrices(int sz, int count);
        int n;
        n = order_of(sz);
        wait_idle();
        cfg_write(ADDR_SIZE, sz);
        repeat (count * n * n) element_q.push_back(rand_element());
    endtask

    initial
    begin
        int sz;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        errors   = 0;
        results_seen   = 0;
        matrices_seen  = 0;
        pivot_err_seen = 0;
        items_sent     = 0;
        load_cnt = 0;
        size_reg = SIZE_RESET;
        repeat (12) @(posedge clk);
        rst_n = 1'b1;

        // order two at the extremes, then a zero pivot
        wait_idle();
        cfg_write(ADDR_SIZE, 2);
        element_q.push_back(MAXV[DW-1:0]);
        element_q.push_back(MINV[DW-1:0]);
        element_q.push_back(ONE[DW-1:0]);
        element_q.push_back(MINV[DW-1:0]);
        element_q.push_back(ONE[DW-1:0]);
        element_q.push_back(DW'(2 * ONE));
        element_q.push_back('0);
        element_q.push_back(DW'(-3 * ONE));
        // order one, and the out-of-range size zero
        wait_idle();
        cfg_write(ADDR_SIZE, 1);
        element_q.push_back(MINV[DW-1:0]);
        element_q.push_back(MAXV[DW-1:0]);
        wait_idle();
        cfg_write(ADDR_SIZE, 0);
        element_q.push_back(48'h5555_AAAA_5555);
        // partly loaded matrix dropped by a rewrite; unused address ignored
        wait_idle();
        cfg_write(ADDR_SIZE, 3);
        repeat (4) element_q.push_back(rand_element());
        wait_idle();
        cfg_write(ADDR_SIZE, 3);
        cfg_write(ADDR_UNUSED, 2);
        repeat (9) element_q.push_back(rand_element());
        send_matrices(15, 1);

        while (items_sent + element_q.size() < 400)
        begin
            case ($urandom_range(0, 15))
                0:       sz = 8;
                1:       sz = $urandom_range(9, 15);
                2:       sz = 0;
                3, 4:    sz = $urandom_range(5, 7);
                default: sz = $urandom_range(1, 4);
            endcase
            send_matrices(sz, (order_of(sz) >= 6) ? 1 : $urandom_range(1, 5));
        end

        wait_idle();
        repeat (100) @(posedge clk);
        $display("run covered %0d elements, %0d matrices (%0d stopped on a zero pivot)",
                 items_sent, matrices_seen, pivot_err_seen);
        $display("orders 1 to 8 plus out-of-range sizes, %0d results checked", results_seen);
        if (errors == 0 && frob_result_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
